[rtl/keypad_scan_number_entry_assert.svh]
// Assertion macros shared by the keypad scanner checks.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef KEYPAD_SCAN_NUMBER_ENTRY_ASSERT_SVH
`define KEYPAD_SCAN_NUMBER_ENTRY_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define KSNE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define KSNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ksne_pkg.sv]
package ksne_pkg;

  // Keypad scanner phases.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SCAN      = 3'd1,
    PH_DECODE    = 3'd2,
    PH_DIGIT_REL = 3'd3,
    PH_DEBOUNCE  = 3'd4,
    PH_TERM_REL  = 3'd5
  } phase_t;

  localparam logic [3:0]  ALL_HIGH       = 4'hF;
  localparam logic [23:0] DEBOUNCE_RESET = 24'd500;
  localparam logic [7:0]  ASCII_ZERO     = 8'd48;
  localparam logic [7:0]  ASCII_NINE     = 8'd57;

  // Key legend, row-major: "123A" / "456B" / "789C" / "*0#=".
  localparam logic [7:0] KEY_MAP [16] = '{
    8'h31, 8'h32, 8'h33, 8'h41,
    8'h34, 8'h35, 8'h36, 8'h42,
    8'h37, 8'h38, 8'h39, 8'h43,
    8'h2A, 8'h30, 8'h23, 8'h3D
  };

  function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    return KEY_MAP[{row, col}];
  endfunction

  function automatic logic is_digit(input logic [7:0] code);
    return (code >= ASCII_ZERO) && (code <= ASCII_NINE);
  endfunction

endpackage

[rtl/keypad_scan_number_entry.sv]
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle, limited only by the single output
// register, which is reloaded in the same cycle its beat is taken.
// Reset (rst_n low, synchronous): phase idle, counters and accumulator zero,
// debounce_ticks back to 500, no result pending.
module keypad_scan_number_entry #(
  parameter int NUMBER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Column samples, one beat per keypad tick.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_column_lines,
  // One result beat per input beat.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_row_drive,
  output logic        out_key_valid,
  output logic [7:0]  out_key_code,
  output logic        out_number_valid,
  output logic [31:0] out_number_value,
  // Debounce length register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_debounce_ticks
);

  localparam int OUT_BITS = 32;
  // Wide enough for both the accumulator and the reported value.
  localparam int EXT_BITS = (NUMBER_BITS > OUT_BITS) ? NUMBER_BITS : OUT_BITS;

  // Scanner state. Every tick is one accepted input beat; the state moves
  // only on those beats, so output stalls simply freeze the scanner.
  ksne_pkg::phase_t         phase_r, phase_nxt;
  logic [1:0]               scan_row_r, scan_row_nxt;
  logic [1:0]               found_row_r, found_row_nxt;
  logic [NUMBER_BITS-1:0]   acc_r, acc_nxt;
  logic [23:0]              wait_r, wait_nxt;
  logic [23:0]              debounce_r;

  // Result register.
  logic                     out_valid_r;
  logic [3:0]               drive_r, drive_nxt;
  logic                     kvalid_r, kvalid_nxt;
  logic [7:0]               kcode_r, kcode_nxt;
  logic                     nvalid_r, nvalid_nxt;
  logic [31:0]              nvalue_r, nvalue_nxt;

  logic                     in_beat;
  logic                     pressed;
  logic                     col_hit;
  logic [1:0]               col_idx;
  logic [7:0]               key;
  logic                     key_is_digit;
  logic [NUMBER_BITS-1:0]   acc_digit;
  logic [EXT_BITS-1:0]      acc_ext;

  // A new beat is taken whenever the result register is empty or is being
  // drained in this same cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign pressed = (in_column_lines != ksne_pkg::ALL_HIGH);

  // Lowest-numbered low column wins when several keys share the row.
  always_comb begin
    col_hit = 1'b1;
    col_idx = 2'd0;
    if (!in_column_lines[0]) begin
      col_idx = 2'd0;
    end else if (!in_column_lines[1]) begin
      col_idx = 2'd1;
    end else if (!in_column_lines[2]) begin
      col_idx = 2'd2;
    end else if (!in_column_lines[3]) begin
      col_idx = 2'd3;
    end else begin
      col_hit = 1'b0;
    end
  end

  assign key          = ksne_pkg::key_lookup(found_row_r, col_idx);
  assign key_is_digit = ksne_pkg::is_digit(key);

  // acc * 10 + digit as two shifted copies and an add; the sum naturally
  // wraps at the accumulator width.
  assign acc_digit = (acc_r << 3) + (acc_r << 1)
                   + NUMBER_BITS'(key[3:0]);
  assign acc_ext   = EXT_BITS'(acc_r);

  // Next-state logic.
  always_comb begin
    phase_nxt     = phase_r;
    scan_row_nxt  = scan_row_r;
    found_row_nxt = found_row_r;
    acc_nxt       = acc_r;
    wait_nxt      = wait_r;
    unique case (phase_r)
      ksne_pkg::PH_SCAN: begin
        if (pressed) begin
          found_row_nxt = scan_row_r;
          phase_nxt     = ksne_pkg::PH_DECODE;
        end else if (scan_row_r == 2'd3) begin
          // Key let go before any row answered.
          scan_row_nxt = 2'd0;
          phase_nxt    = ksne_pkg::PH_IDLE;
        end else begin
          scan_row_nxt = scan_row_r + 2'd1;
        end
      end
      ksne_pkg::PH_DECODE: begin
        if (!col_hit) begin
          phase_nxt = ksne_pkg::PH_IDLE;
        end else if (key_is_digit) begin
          acc_nxt   = acc_digit;
          phase_nxt = ksne_pkg::PH_DIGIT_REL;
        end else begin
          acc_nxt   = '0;
          phase_nxt = ksne_pkg::PH_TERM_REL;
        end
      end
      ksne_pkg::PH_DIGIT_REL: begin
        if (!pressed) begin
          if (debounce_r == 24'd0) begin
            phase_nxt = ksne_pkg::PH_IDLE;
          end else begin
            wait_nxt  = debounce_r;
            phase_nxt = ksne_pkg::PH_DEBOUNCE;
          end
        end
      end
      ksne_pkg::PH_DEBOUNCE: begin
        if (wait_r != 24'd0) begin
          wait_nxt = wait_r - 24'd1;
        end
        if ((wait_r == 24'd0) || (wait_r == 24'd1)) begin
          phase_nxt = ksne_pkg::PH_IDLE;
        end
      end
      ksne_pkg::PH_TERM_REL: begin
        if (!pressed) begin
          phase_nxt = ksne_pkg::PH_IDLE;
        end
      end
      default: begin
        // Idle, and any unused phase code behaves like idle.
        phase_nxt = ksne_pkg::PH_IDLE;
        if (pressed) begin
          scan_row_nxt = 2'd0;
          phase_nxt    = ksne_pkg::PH_SCAN;
        end
      end
    endcase
  end

  // Result logic for the current beat.
  always_comb begin
    drive_nxt  = 4'h0;
    kvalid_nxt = 1'b0;
    kcode_nxt  = 8'h00;
    nvalid_nxt = 1'b0;
    nvalue_nxt = 32'h0;
    unique case (phase_r)
      ksne_pkg::PH_SCAN: begin
        // Ground only the row under test.
        drive_nxt = ksne_pkg::ALL_HIGH ^ (4'b0001 << scan_row_r);
      end
      ksne_pkg::PH_DECODE: begin
        if (col_hit) begin
          kvalid_nxt = 1'b1;
          kcode_nxt  = key;
          if (!key_is_digit) begin
            nvalid_nxt = 1'b1;
            nvalue_nxt = acc_ext[OUT_BITS-1:0];
          end
        end
      end
      default: begin
        drive_nxt = 4'h0;
      end
    endcase
  end

  // Scanner state and debounce register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ksne_pkg::PH_IDLE;
      scan_row_r  <= 2'd0;
      found_row_r <= 2'd0;
      acc_r       <= '0;
      wait_r      <= 24'd0;
      debounce_r  <= ksne_pkg::DEBOUNCE_RESET;
    end else begin
      if (in_beat) begin
        phase_r     <= phase_nxt;
        scan_row_r  <= scan_row_nxt;
        found_row_r <= found_row_nxt;
        acc_r       <= acc_nxt;
        wait_r      <= wait_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        debounce_r <= cfg_debounce_ticks;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded with each accepted beat and held otherwise.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      drive_r  <= drive_nxt;
      kvalid_r <= kvalid_nxt;
      kcode_r  <= kcode_nxt;
      nvalid_r <= nvalid_nxt;
      nvalue_r <= nvalue_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_drive    = drive_r;
  assign out_key_valid    = kvalid_r;
  assign out_key_code     = kcode_r;
  assign out_number_valid = nvalid_r;
  assign out_number_value = nvalue_r;

endmodule

[rtl/ksne_checker.sv]
`include "keypad_scan_number_entry_assert.svh"

module ksne_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_row_drive,
  input logic        out_key_valid,
  input logic [7:0]  out_key_code,
  input logic        out_number_valid,
  input logic [31:0] out_number_value
);

  // Every accepted column beat leaves a result beat waiting on the next cycle.
  `KSNE_ASSERT_NEXT(a_beat_result, in_valid && in_ready, out_valid, "input beat without result")

  // A stalled result beat keeps its key code, number value and row drive.
  `KSNE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_key_code) && $stable(out_number_value) && $stable(out_row_drive), "stalled result changed")

  // A completed number always comes with its terminating key.
  `KSNE_ASSERT_NOW(a_num_has_key, out_valid && out_number_valid, out_key_valid && !(out_key_code >= ksne_pkg::ASCII_ZERO && out_key_code <= ksne_pkg::ASCII_NINE), "number without terminator key")

  // Keys are decoded only with every row grounded.
  `KSNE_ASSERT_NOW(a_key_drive, out_valid && out_key_valid, out_row_drive == 4'h0, "key decoded while scanning")

  // Without a decoded key the code and number fields are clear.
  `KSNE_ASSERT_NOW(a_idle_fields, out_valid && !out_key_valid, out_key_code == 8'h00 && !out_number_valid && out_number_value == 32'h0, "stray result fields")

endmodule

bind keypad_scan_number_entry ksne_checker u_ksne_checker (.*);
